### rtl/cps_pkg.sv
// Shared types and constants for the clock polynomial shift block.
`default_nettype none

package cps_pkg;

  localparam int NCOEF   = 6;    // coefficient lanes, orders 0..5
  localparam int CW      = 64;   // coefficient width
  localparam int IN_W    = 48;   // sample / epoch time width
  localparam int DTW     = 49;   // time difference width
  localparam int TC_W    = 3;    // term count width
  localparam int TC_LSB  = NCOEF * CW;
  localparam int OUT_W   = 392;  // result word, padded to whole bytes
  localparam int CFG_IDX_W = 3;
  localparam int DT_FRAC = 16;   // fraction bits of the time difference
  localparam int PW      = 113;  // |acc| * |dt| plus rounding
  localparam int QW      = PW - DT_FRAC;

  localparam logic [CW-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CW-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef logic [CW-1:0]            coef_t;
  typedef coef_t [NCOEF-1:0]        lane_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER = 3'd0,
    REG_EPOCH = 3'd1,
    REG_COEF0 = 3'd2,
    REG_COEF1 = 3'd3,
    REG_COEF2 = 3'd4,
    REG_COEF3 = 3'd5,
    REG_COEF4 = 3'd6,
    REG_COEF5 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [IN_W-1:0] epoch;
    logic [TC_W-1:0] term_count;
  } cps_ctl_t;

endpackage

`default_nettype wire

### rtl/cps_cfg.sv
// Configuration registers and the binomial-weighted term table.
`default_nettype none

module cps_cfg #(
  parameter int MAX_ORDER = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire cps_pkg::coef_t               cfg_data,
  output cps_pkg::cps_ctl_t                 ctl_o,
  output cps_pkg::lane_vec_t                init_o,
  output cps_pkg::lane_vec_t                sterm_o [1:MAX_ORDER],
  output logic [cps_pkg::NCOEF-1:0]         sact_o  [1:MAX_ORDER]
);
  import cps_pkg::*;

  localparam logic [3:0] BINOM [NCOEF][NCOEF] = '{
    '{4'd1, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd2, 4'd1,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd3, 4'd3,  4'd1,  4'd0, 4'd0},
    '{4'd1, 4'd4, 4'd6,  4'd4,  4'd1, 4'd0},
    '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1}
  };
  localparam logic [2:0] MAXO = 3'(MAX_ORDER);

  logic [2:0]      ord_raw_r;
  logic [IN_W-1:0] epoch_r;
  coef_t           coef_r [NCOEF];
  logic [2:0]      ord;
  coef_t           tt [NCOEF][NCOEF];
  lane_vec_t       init_nxt, init_r;
  lane_vec_t       sterm_nxt [1:MAX_ORDER];
  lane_vec_t       sterm_r   [1:MAX_ORDER];
  logic [NCOEF-1:0] sact_nxt [1:MAX_ORDER];
  logic [NCOEF-1:0] sact_r   [1:MAX_ORDER];

  // coefficient times small binomial, clamped to 64 bits
  function automatic coef_t sat_scale(input coef_t c, input logic [3:0] b);
    logic [67:0] prod;
    prod = {{4{c[63]}}, c} * 68'(b);
    if (prod[67:63] == 5'b00000 || prod[67:63] == 5'b11111) begin
      return prod[63:0];
    end
    return prod[67] ? SAT_MIN : SAT_MAX;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_raw_r <= '0;
      epoch_r   <= '0;
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORDER: ord_raw_r <= cfg_data[2:0];
        REG_EPOCH: epoch_r   <= cfg_data[IN_W-1:0];
        REG_COEF0: coef_r[0] <= cfg_data;
        REG_COEF1: coef_r[1] <= cfg_data;
        REG_COEF2: coef_r[2] <= cfg_data;
        REG_COEF3: coef_r[3] <= cfg_data;
        REG_COEF4: coef_r[4] <= cfg_data;
        REG_COEF5: coef_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // orders above the build limit fold down to it
  assign ord = (ord_raw_r > MAXO) ? MAXO : ord_raw_r;

  always_comb begin
    for (int j = 0; j < NCOEF; j++) begin
      for (int k = 0; k < NCOEF; k++) begin
        tt[j][k] = (k <= j) ? sat_scale(coef_r[j], BINOM[j][k]) : '0;
      end
    end
  end

  // step s of lane k uses term (ord-s, k) and runs only while ord-s >= k
  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      init_nxt[k] = ({1'b0, ord} >= 4'(k)) ? tt[ord][k] : '0;
    end
    for (int s = 1; s <= MAX_ORDER; s++) begin
      for (int k = 0; k < NCOEF; k++) begin
        sact_nxt[s][k]  = ({1'b0, ord} >= 4'(s + k));
        sterm_nxt[s][k] = '0;
        if (sact_nxt[s][k]) begin
          sterm_nxt[s][k] = tt[ord - 3'(s)][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
      for (int s = 1; s <= MAX_ORDER; s++) begin
        sterm_r[s] <= '0;
        sact_r[s]  <= '0;
      end
    end else begin
      init_r <= init_nxt;
      for (int s = 1; s <= MAX_ORDER; s++) begin
        sterm_r[s] <= sterm_nxt[s];
        sact_r[s]  <= sact_nxt[s];
      end
    end
  end

  assign ctl_o.epoch      = epoch_r;
  assign ctl_o.term_count = ord + 3'd1;
  assign init_o           = init_r;
  assign sterm_o          = sterm_r;
  assign sact_o           = sact_r;

endmodule

`default_nettype wire

### rtl/cps_hstep.sv
// One Horner step of one lane: acc = sat(round(acc*dt)) + term, four stages.
`default_nettype none

module cps_hstep (
  input  wire logic                   clk,
  input  wire logic [3:0]             en_i,   // stage enables A..D
  input  wire logic                   act_i,  // step in use for this order
  input  wire cps_pkg::coef_t         acc_i,
  input  wire logic                   dtn_i,  // dt sign, seen at stage A
  input  wire logic [cps_pkg::DTW-1:0] dtm_i, // |dt|, seen at stage B
  input  wire cps_pkg::coef_t         term_i,
  output cps_pkg::coef_t              acc_o
);
  import cps_pkg::*;

  // stage A: magnitude and product sign
  coef_t           mag_r, acca_r;
  logic            nega_r;
  // stage B: partial products
  logic [63:0]     pp00_r, pp10_r;
  logic [48:0]     pp01_r, pp11_r;
  coef_t           accb_r;
  logic            negb_r;
  // stage C: rounded, scaled magnitude
  logic [QW-1:0]   q_r;
  coef_t           accc_r;
  logic            negc_r;
  logic [PW-1:0]   sum;
  // stage D
  coef_t           acc_r;
  coef_t           lim, m, sx;
  logic            over, p_sgn, ovf;

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      mag_r  <= acc_i[CW-1] ? (~acc_i + 64'd1) : acc_i;
      nega_r <= acc_i[CW-1] ^ dtn_i;
      acca_r <= acc_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      pp00_r <= mag_r[31:0]  * dtm_i[31:0];
      pp01_r <= mag_r[31:0]  * dtm_i[48:32];
      pp10_r <= mag_r[63:32] * dtm_i[31:0];
      pp11_r <= mag_r[63:32] * dtm_i[48:32];
      negb_r <= nega_r;
      accb_r <= acca_r;
    end
  end

  // round half away from zero on the magnitude
  assign sum = PW'(pp00_r) + (PW'(pp01_r) << 32) + (PW'(pp10_r) << 32)
             + (PW'(pp11_r) << 64) + (PW'(1) << (DT_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      q_r    <= sum[PW-1:DT_FRAC];
      negc_r <= negb_r;
      accc_r <= accb_r;
    end
  end

  // clamp, apply sign, add term with a single carry-in add
  always_comb begin
    lim   = negc_r ? SAT_MIN : SAT_MAX;
    over  = (|q_r[QW-1:CW]) | (q_r[CW-1:0] > lim);
    m     = over ? lim : q_r[CW-1:0];
    p_sgn = negc_r & (|m);
    sx    = term_i + (m ^ {CW{negc_r}}) + CW'(negc_r);
    ovf   = (p_sgn == term_i[CW-1]) & (sx[CW-1] != term_i[CW-1]);
  end

  always_ff @(posedge clk) begin
    if (en_i[3]) begin
      if (!act_i) begin
        acc_r <= accc_r;
      end else if (ovf) begin
        acc_r <= p_sgn ? SAT_MIN : SAT_MAX;
      end else begin
        acc_r <= sx;
      end
    end
  end

  assign acc_o = acc_r;

endmodule

`default_nettype wire

### rtl/clock_polynomial_shift.sv
// Top level: clock polynomial re-expansion about a sample time, pipelined.
// Throughput: one sample per cycle unless the output stalls; each lane has its own unit for every Horner step it needs.
// Stalls back up stage by stage; empty stages keep accepting while a result waits.
// Reset (rst_n low, synchronous) clears valids and all config registers to zero.
`default_nettype none

module clock_polynomial_shift #(
  parameter int MAX_ORDER = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [cps_pkg::IN_W-1:0]     in_tdata,   // [47:0] sample_time
  // result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [63:0] shifted_c0, [127:64] shifted_c1, [191:128] shifted_c2,
  // [255:192] shifted_c3, [319:256] shifted_c4, [383:320] shifted_c5,
  // [386:384] term_count, [391:387] zero
  output logic [cps_pkg::OUT_W-1:0]         out_tdata,
  // config write port
  input  wire logic                         cfg_we,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire cps_pkg::coef_t               cfg_data
);
  import cps_pkg::*;

  // stage 0: sample register
  // stage 1: dt sign/magnitude, initial accumulators
  // step s: stages 4s-2 .. 4s+1 (A: abs, B: partial products, C: sum, D: sat add)
  localparam int N   = 4 * MAX_ORDER + 2;
  localparam int DTL = 4 * MAX_ORDER - 2;

  cps_ctl_t         ctl;
  lane_vec_t        init;
  lane_vec_t        sterm [1:MAX_ORDER];
  logic [NCOEF-1:0] sact  [1:MAX_ORDER];

  logic [N-1:0]     vld_r;
  logic [N-1:0]     en;

  logic [IN_W-1:0]  smp_r;
  logic [DTW-1:0]   dtm_r [1:DTL];
  logic             dtn_r [1:DTL-1];
  coef_t            acc1_r [NCOEF];
  coef_t            lacc [0:MAX_ORDER][NCOEF];

  logic [DTW-1:0]   d_fwd, d_rev;

  cps_cfg #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl_o     (ctl),
    .init_o    (init),
    .sterm_o   (sterm),
    .sact_o    (sact)
  );

  // a stage loads when it or some stage downstream has room
  for (genvar i = 0; i < N; i++) begin : g_en
    assign en[i] = out_tready | ~(&vld_r[N-1:i]);
  end

  assign in_tready = en[0] & rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) smp_r <= in_tdata;
  end

  // both differences at once, pick the non-negative one
  assign d_fwd = {smp_r[IN_W-1], smp_r} - {ctl.epoch[IN_W-1], ctl.epoch};
  assign d_rev = {ctl.epoch[IN_W-1], ctl.epoch} - {smp_r[IN_W-1], smp_r};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dtn_r[1] <= d_fwd[DTW-1];
      dtm_r[1] <= d_fwd[DTW-1] ? d_rev : d_fwd;
      for (int k = 0; k < NCOEF; k++) acc1_r[k] <= init[k];
    end
  end

  // dt travels alongside the accumulators
  for (genvar i = 2; i <= DTL; i++) begin : g_dtm
    always_ff @(posedge clk) begin
      if (en[i]) dtm_r[i] <= dtm_r[i-1];
    end
  end
  for (genvar i = 2; i <= DTL - 1; i++) begin : g_dtn
    always_ff @(posedge clk) begin
      if (en[i]) dtn_r[i] <= dtn_r[i-1];
    end
  end

  for (genvar k = 0; k < NCOEF; k++) begin : g_l0
    assign lacc[0][k] = acc1_r[k];
  end

  // lane k needs steps 1 .. MAX_ORDER-k; later slots are plain delays
  for (genvar s = 1; s <= MAX_ORDER; s++) begin : g_step
    localparam int A = 4 * s - 2;
    for (genvar k = 0; k < NCOEF; k++) begin : g_lane
      if (s + k <= MAX_ORDER) begin : g_unit
        cps_hstep u_hstep (
          .clk    (clk),
          .en_i   ({en[A+3], en[A+2], en[A+1], en[A]}),
          .act_i  (sact[s][k]),
          .acc_i  (lacc[s-1][k]),
          .dtn_i  (dtn_r[A-1]),
          .dtm_i  (dtm_r[A]),
          .term_i (sterm[s][k]),
          .acc_o  (lacc[s][k])
        );
      end else begin : g_dly
        coef_t dly_r [4];
        always_ff @(posedge clk) begin
          if (en[A])   dly_r[0] <= lacc[s-1][k];
          if (en[A+1]) dly_r[1] <= dly_r[0];
          if (en[A+2]) dly_r[2] <= dly_r[1];
          if (en[A+3]) dly_r[3] <= dly_r[2];
        end
        assign lacc[s][k] = dly_r[3];
      end
    end
  end

  assign out_tvalid = vld_r[N-1];

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NCOEF; k++) begin
      out_tdata[k*CW +: CW] = lacc[MAX_ORDER][k];
    end
    out_tdata[TC_LSB +: TC_W] = ctl.term_count;
  end

endmodule

`default_nettype wire

### rtl/cps_checker.sv
// Port-level checks for the clock polynomial shift block, bound to the top.
`default_nettype none

module cps_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cps_pkg::OUT_W-1:0]     out_tdata
);
  import cps_pkg::*;

  logic [TC_W-1:0] tc;
  assign tc = out_tdata[TC_LSB +: TC_W];

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // with no result pending every stage has room
  a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // input only stalls when the output stalls
  a_rdy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // a held result keeps its coefficients
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata[TC_LSB-1:0]))
    else $error("held result changed");

  // term count is order plus one, never zero or seven
  a_tc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (tc != 3'd0) && (tc != 3'd7))
    else $error("term count out of range");

endmodule

bind clock_polynomial_shift cps_checker u_cps_checker (.*);

`default_nettype wire

### tb/tb.sv
// Testbench for clock_polynomial_shift: directed table, then random phases, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import cps_pkg::*;

  localparam int MAX_ORD    = 5;
  localparam int NPHASE     = 10;
  localparam int PHASE_REQS = 115;       // requests per random phase
  localparam int TAIL_CYC   = 40;        // idle cycles after the last result
  localparam int LIMIT_NS   = 1_000_000;
  localparam int PRINT_CAP  = 60;

  localparam logic [IN_W-1:0] T_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [IN_W-1:0] T_MIN = 48'h8000_0000_0000;

  // Hand-picked clock model for the directed rows; dt = 0 returns it unchanged.
  localparam coef_t K0 = 64'h0000_2A3B_4C5D_6E7F;
  localparam coef_t K1 = 64'hFFFF_FFF1_2345_6789;
  localparam coef_t K2 = 64'h0000_0000_0123_4567;
  localparam coef_t K3 = 64'hFFFF_FFFF_FFFE_DCBA;
  localparam coef_t K4 = 64'h0000_0000_0000_1357;
  localparam coef_t K5 = 64'hFFFF_FFFF_FFFF_FF9B;
  localparam logic [IN_W-1:0] EP_K = 48'h0001_86A0_4000;

  // One result request: the six re-expanded coefficients and the term count.
  typedef struct packed {
    logic [TC_W-1:0] term_count;
    lane_vec_t       lanes;
  } clk_terms_t;

  // One row of the directed table: a register write or a sample request.
  typedef struct packed {
    bit              is_write;
    cfg_reg_t        idx;
    coef_t           wdata;
    logic [IN_W-1:0] t;
    bit              typed;      // want holds a hand-typed result
    clk_terms_t      want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  coef_t                cfg_data;

  // Shadow of the block's registers, updated on every write.
  logic [2:0]      model_order = '0;
  logic [IN_W-1:0] model_epoch = '0;
  coef_t           model_coef [NCOEF];

  clk_terms_t pending_terms [$];   // expected results, oldest first
  dir_row_t   script [$];
  int         gap_pct   = 0;       // chance of an idle cycle before each request
  int         stall_pct = 0;       // chance of out_tready low in a cycle
  int         mismatch_count = 0;

  clock_polynomial_shift DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),      // [47:0] sample_time
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [63:0] shifted_c0 ... [383:320] shifted_c5, [386:384] term_count, [391:387] zero
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #(LIMIT_NS);
    $display("clock_polynomial_shift verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: saturating fixed-point Horner evaluation of every shifted term.
  // ---------------------------------------------------------------------------

  function automatic coef_t choose(int n, int r);
    int c;
    c = 1;
    for (int i = 0; i < r; i++) c = c * (n - i) / (i + 1);
    return coef_t'(c);
  endfunction

  // Signed multiply on sign/magnitude, optional round-half-away shift, clamp.
  function automatic coef_t mul_sat(coef_t a, coef_t b, int sh);
    logic         neg;
    coef_t        x, y;
    logic [127:0] p, lim;
    neg = a[63] ^ b[63];
    x = a[63] ? -a : a;
    y = b[63] ? -b : b;
    p = {64'd0, x} * {64'd0, y};
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? {64'd0, SAT_MIN} : {64'd0, SAT_MAX};
    if (p > lim) p = lim;
    return neg ? -p[63:0] : p[63:0];
  endfunction

  function automatic coef_t add_sat(coef_t a, coef_t b);
    coef_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? SAT_MIN : SAT_MAX;
    return s;
  endfunction

  function automatic clk_terms_t reexpand(logic [IN_W-1:0] t);
    clk_terms_t r;
    coef_t      dt, acc;
    int         ord;
    r = '0;
    // exact 49-bit difference, carried sign-extended in 64 bits
    dt = {{16{t[IN_W-1]}}, t} - {{16{model_epoch[IN_W-1]}}, model_epoch};
    ord = (model_order > MAX_ORD) ? MAX_ORD : int'(model_order);
    for (int k = 0; k <= ord; k++) begin
      acc = mul_sat(model_coef[ord], choose(ord, k), 0);
      for (int j = ord - 1; j >= k; j--)
        acc = add_sat(mul_sat(acc, dt, DT_FRAC), mul_sat(model_coef[j], choose(j, k), 0));
      r.lanes[k] = acc;
    end
    r.term_count = TC_W'(ord + 1);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic dir_row_t wr_row(cfg_reg_t idx, coef_t v);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.wdata = v;
    return r;
  endfunction

  function automatic dir_row_t sample_row(logic [IN_W-1:0] t);
    dir_row_t r;
    r = '0;
    r.t = t;
    return r;
  endfunction

  function automatic dir_row_t checked_row(logic [IN_W-1:0] t, lane_vec_t lanes,
                                           logic [TC_W-1:0] tc);
    dir_row_t r;
    r = '0;
    r.t = t;
    r.typed = 1'b1;
    r.want.lanes = lanes;
    r.want.term_count = tc;
    return r;
  endfunction

  // Coefficients: half scaled-down random values, some full-width random, some rails and zero.
  function automatic coef_t rand_coef();
    coef_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = SAT_MAX;
      1: v = SAT_MIN;
      2: v = '0;
      3, 4: ;
      default: v = coef_t'($signed(v) >>> $urandom_range(1, 62));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, coef_t got, coef_t want);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // Hold requests off until every expected result has come back.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  // Register writes only ever land on an empty pipeline.
  task automatic write_reg(cfg_reg_t idx, coef_t v);
    wait_results_done();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_ORDER: model_order = v[2:0];
      REG_EPOCH: model_epoch = v[IN_W-1:0];
      default:   model_coef[idx - REG_COEF0] = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one sample request; the expectation is queued at the accepting edge.
  // in_tvalid stays high across back-to-back requests.
  task automatic push_sample(logic [IN_W-1:0] t, bit typed, clk_terms_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_terms.push_back(typed ? want : reexpand(t));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, scoreboard compare on each accepted result
  // ---------------------------------------------------------------------------
  initial begin
    clk_terms_t got, want;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.lanes = out_tdata[TC_LSB-1:0];
        got.term_count = out_tdata[TC_LSB +: TC_W];
        if (pending_terms.size() == 0) begin
          flag_mismatch("result with nothing expected", got.lanes[0], '0);
        end else begin
          want = pending_terms.pop_front();
          for (int k = 0; k < NCOEF; k++)
            if (got.lanes[k] !== want.lanes[k])
              flag_mismatch($sformatf("shifted_c%0d", k), got.lanes[k], want.lanes[k]);
          if (got.term_count !== want.term_count)
            flag_mismatch("term_count", coef_t'(got.term_count), coef_t'(want.term_count));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [2:0]      ord_v;
    logic [IN_W-1:0] ep, t;
    coef_t           c;
    clk_terms_t      none;

    none = '0;
    for (int k = 0; k < NCOEF; k++) model_coef[k] = '0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ORDER;
    cfg_data  <= '0;

    // After reset: order 0, all coefficients zero, so every result is zero.
    script.push_back(checked_row(48'h0, '0, 3'd1));
    script.push_back(checked_row(T_MAX, '0, 3'd1));
    script.push_back(checked_row(T_MIN, '0, 3'd1));
    // Constant model at the positive rail.
    script.push_back(wr_row(REG_COEF0, SAT_MAX));
    script.push_back(checked_row(48'h1234_5678_9ABC, {320'd0, SAT_MAX}, 3'd1));
    // Full model; order codes 7 and 6 clamp to 5. At dt = 0 the terms come back as is.
    script.push_back(wr_row(REG_COEF0, K0));
    script.push_back(wr_row(REG_COEF1, K1));
    script.push_back(wr_row(REG_COEF2, K2));
    script.push_back(wr_row(REG_COEF3, K3));
    script.push_back(wr_row(REG_COEF4, K4));
    script.push_back(wr_row(REG_COEF5, K5));
    script.push_back(wr_row(REG_EPOCH, {16'd0, EP_K}));
    script.push_back(wr_row(REG_ORDER, 64'd7));
    script.push_back(checked_row(EP_K, {K5, K4, K3, K2, K1, K0}, 3'd6));
    script.push_back(wr_row(REG_ORDER, 64'd6));
    script.push_back(checked_row(EP_K, {K5, K4, K3, K2, K1, K0}, 3'd6));
    script.push_back(wr_row(REG_ORDER, 64'd5));
    script.push_back(sample_row(EP_K + 48'h0000_0001_0000));
    script.push_back(sample_row(EP_K - 48'h0000_3039_8000));
    script.push_back(sample_row(T_MAX));
    script.push_back(sample_row(T_MIN));
    // Unused terms read as zero even though their registers hold values.
    script.push_back(wr_row(REG_ORDER, 64'd3));
    script.push_back(checked_row(EP_K, {128'd0, K3, K2, K1, K0}, 3'd4));
    script.push_back(sample_row(EP_K + 48'h0000_0010_0000));
    script.push_back(wr_row(REG_ORDER, 64'd1));
    script.push_back(checked_row(EP_K, {256'd0, K1, K0}, 3'd2));
    // Rounding: a1 = one LSB, dt = +/- half a second rounds away from zero.
    script.push_back(wr_row(REG_EPOCH, 64'd0));
    script.push_back(wr_row(REG_COEF0, 64'd0));
    script.push_back(wr_row(REG_COEF1, 64'd1));
    script.push_back(checked_row(48'h0000_0000_8000, {256'd0, 64'd1, 64'd1}, 3'd2));
    script.push_back(checked_row(48'hFFFF_FFFF_8000, {256'd0, 64'd1, {64{1'b1}}}, 3'd2));
    script.push_back(checked_row(48'h0000_0000_7FFF, {256'd0, 64'd1, 64'd0}, 3'd2));
    // Rails: widest dt both ways, all coefficients at one rail.
    script.push_back(wr_row(REG_ORDER, 64'd5));
    for (int k = 0; k < NCOEF; k++)
      script.push_back(wr_row(cfg_reg_t'(REG_COEF0 + k), SAT_MAX));
    script.push_back(wr_row(REG_EPOCH, {16'hA5A5, T_MIN}));   // upper bits ignored
    script.push_back(sample_row(T_MAX));
    script.push_back(sample_row(T_MIN));
    for (int k = 0; k < NCOEF; k++)
      script.push_back(wr_row(cfg_reg_t'(REG_COEF0 + k), SAT_MIN));
    script.push_back(wr_row(REG_EPOCH, {16'h5A5A, T_MAX}));
    script.push_back(sample_row(T_MIN));
    script.push_back(sample_row(T_MAX));
    // Only the low three bits of the order register count: this is order 0.
    script.push_back(wr_row(REG_ORDER, 64'hFFFF_FFFF_FFFF_FFF8));
    script.push_back(checked_row(T_MAX, {320'd0, SAT_MIN}, 3'd1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 35;
    stall_pct = 35;
    foreach (script[i]) begin
      if (script[i].is_write) write_reg(script[i].idx, script[i].wdata);
      else push_sample(script[i].t, script[i].typed, script[i].want);
    end

    // Random phases: a new clock model per phase, idle pattern rotating.
    for (int p = 0; p < NPHASE; p++) begin
      ord_v = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      if (p == 2) ep = T_MIN;
      else if (p == 7) ep = T_MAX;
      else begin
        ep = IN_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
          0: ep = '0;
          1: ep = IN_W'($signed(ep) >>> $urandom_range(8, 40));
          default: ;
        endcase
      end
      // junk above the register widths must be dropped
      write_reg(REG_ORDER, {$urandom, 29'($urandom), ord_v});
      write_reg(REG_EPOCH, {16'($urandom), ep});
      for (int k = 0; k < NCOEF; k++) begin
        c = (p == 2) ? SAT_MAX : (p == 7) ? SAT_MIN : rand_coef();
        write_reg(cfg_reg_t'(REG_COEF0 + k), c);
      end

      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase

      for (int n = 0; n < PHASE_REQS; n++) begin
        // odd phases: sender goes quiet mid-phase until the pipeline drains
        if (p % 2 == 1 && n == 57) wait_results_done();
        t = IN_W'({$urandom, $urandom});
        case ($urandom_range(0, 9))
          0: ;                                   // anywhere in the 48-bit range
          1: t = T_MIN;
          2: t = T_MAX;
          3: t = ep;
          default: t = ep + IN_W'($signed($urandom) >>> $urandom_range(0, 16));
        endcase
        push_sample(t, 1'b0, none);
      end
    end

    wait_results_done();
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0 && pending_terms.size() == 0) begin
      $display("clock_polynomial_shift verification clean");
    end else begin
      $display("clock_polynomial_shift verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cps_pkg.sv
rtl/cps_cfg.sv
rtl/cps_hstep.sv
rtl/clock_polynomial_shift.sv
rtl/cps_checker.sv
tb/tb.sv
